// File: sv/mssn_pkg.sv
// Package for the seven-segment number scan core.
// Holds sizes, microcode types, the control ROM and the segment table.
// No dependencies.
package mssn_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int NUM_W      = 27;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int BITS_W     = $clog2(NUM_W + 1);
    localparam int STEP_W     = 2;

    localparam logic [7:0] SEL_FIRST = 8'hfe;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT  = 2'd0;
    localparam t_step STEP_CONV  = 2'd1;
    localparam t_step STEP_STRIP = 2'd2;
    localparam t_step STEP_EMIT  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CONV  = 2'd1,
        OP_STRIP = 2'd2,
        OP_EMIT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op   op;
        logic  jump;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic hold;
    } t_status;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{op: OP_LOAD, jump: 1'b0, target: STEP_WAIT};
        case (step)
            STEP_WAIT:  w = '{op: OP_LOAD,  jump: 1'b0, target: STEP_WAIT};
            STEP_CONV:  w = '{op: OP_CONV,  jump: 1'b0, target: STEP_WAIT};
            STEP_STRIP: w = '{op: OP_STRIP, jump: 1'b0, target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  jump: 1'b1, target: STEP_WAIT};
            default:    w = '{op: OP_LOAD,  jump: 1'b1, target: STEP_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] seg_lut(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: sv/mssn_seq.sv
// Microcode sequencer: step counter and control ROM.
// Depends on mssn_pkg.
module mssn_seq
    import mssn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_step;
    t_step n_step;

    assign o_ctrl = ucode(r_step);

    always_comb begin
        if (i_status.hold) begin
            n_step = r_step;
        end else if (o_ctrl.jump) begin
            n_step = o_ctrl.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: sv/mssn_datapath.sv
// Datapath: shift-add-3 binary to BCD, leading zero strip, digit scan-out.
// Depends on mssn_pkg; driven by the control word of mssn_seq.
module mssn_datapath
    import mssn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctrl,
    output t_status          o_status,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [NUM_W-1:0] i_number,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_segments,
    output logic [7:0]       o_select,
    output logic [3:0]       o_digit,
    output logic             o_last
);

    logic [NUM_W-1:0]  r_bin,  n_bin;
    logic [BCD_W-1:0]  r_bcd,  n_bcd;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [7:0]        r_sel,  n_sel;
    logic [BCD_W-1:0]  adj;
    logic [3:0]        top;

    assign top         = r_bcd[BCD_W-1 -: 4];
    assign o_in_ready  = (i_ctrl.op == OP_LOAD);
    assign o_out_valid = (i_ctrl.op == OP_EMIT);
    assign o_segments  = seg_lut(top);
    assign o_select    = r_sel;
    assign o_digit     = top;
    assign o_last      = (r_cnt == CNT_W'(1));

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_bin         = r_bin;
        n_bcd         = r_bcd;
        n_bits        = r_bits;
        n_cnt         = r_cnt;
        n_sel         = r_sel;
        o_status.hold = 1'b0;
        case (i_ctrl.op)
            OP_LOAD: begin
                o_status.hold = !i_in_valid;
                if (i_in_valid) begin
                    n_bin  = i_number;
                    n_bcd  = '0;
                    n_bits = BITS_W'(NUM_W);
                    n_cnt  = CNT_W'(MAX_DIGITS);
                    n_sel  = SEL_FIRST;
                end
            end
            OP_CONV: begin
                n_bcd         = {adj[BCD_W-2:0], r_bin[NUM_W-1]};
                n_bin         = {r_bin[NUM_W-2:0], 1'b0};
                n_bits        = r_bits - BITS_W'(1);
                o_status.hold = (r_bits != BITS_W'(1));
            end
            OP_STRIP: begin
                if (top == 4'd0 && r_cnt > CNT_W'(1)) begin
                    n_bcd         = r_bcd << 4;
                    n_cnt         = r_cnt - CNT_W'(1);
                    o_status.hold = 1'b1;
                end
            end
            OP_EMIT: begin
                o_status.hold = !(i_out_ready && o_last);
                if (i_out_ready) begin
                    n_bcd = r_bcd << 4;
                    n_cnt = r_cnt - CNT_W'(1);
                    n_sel = {r_sel[6:0], r_sel[7]};
                end
            end
            default: begin
                o_status.hold = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_sel  <= n_sel;
    end

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> top <= 4'd9)
        else $error("scanned digit out of range");

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("digit count underflow");

endmodule

// File: sv/multiplexed_seven_segment_number_scan_core.sv
// Multiplexed seven-segment number scan, top level.
// Depends on mssn_pkg, mssn_seq and mssn_datapath.
//
// Usage:
//   s_axis takes one word: the number to show (bits [26:0]).
//   m_axis gives one word per significant decimal digit, most significant
//   first, no leading zeros (zero shows one 0). tlast marks the final digit.
//   The select starts at 0xfe and rotates left once per digit.
//   Values of 10^8 or more keep their low eight decimal digits.
// Timing:
//   One number at a time. After acceptance, the shift-add-3 conversion runs
//   over all 27 input bits, then the strip step drops each leading zero, then
//   one digit per cycle while m_axis_tready is high. After the last digit is
//   taken the sequencer returns to the wait step for the next number.
//   s_axis_tready is high only in the wait step.
// Stalls: a digit holds on m_axis until taken; nothing is dropped.
// Reset: synchronous, active low; the sequencer returns to the wait step.
module multiplexed_seven_segment_number_scan_core
    import mssn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [26:0] number_value, [31:27] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] segments, [15:8] digit_select,
                                        // [19:16] digit_value, [23:20] zero
    output logic        m_axis_tlast
);

    t_ctrl      ctrl;
    t_status    status;
    logic [7:0] segments;
    logic [7:0] select;
    logic [3:0] digit;

    mssn_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    mssn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_number    (s_axis_tdata[NUM_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_segments  (segments),
        .o_select    (select),
        .o_digit     (digit),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, digit, select, segments};

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output active together");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("took a second number while busy");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not back in wait after last digit");

    a_first_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> m_axis_tdata[15:8] == SEL_FIRST)
        else $error("first digit select wrong");

endmodule

// File: tb/multiplexed_seven_segment_number_scan_core_tb.sv
// Testbench for multiplexed_seven_segment_number_scan_core: sends numbers, checks digit words.
// A scoreboard class predicts the segments, digit values, selects and tlast; depends on mssn_pkg and the core.
`timescale 1ns / 1ps

module multiplexed_seven_segment_number_scan_core_tb
    import mssn_pkg::*;
();

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_ITEMS  = 75;

    typedef struct {
        logic [7:0] segs;
        logic [7:0] sel;
        logic [3:0] value;
        logic       last;
    } t_digit_word;

    class t_digit_tracker;
        t_digit_word pending_digits[$];
        int unsigned mismatches;
        int unsigned digits_checked;
        int unsigned numbers_noted;
        logic [7:0]  glyph[10];

        function new();
            glyph = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
            mismatches     = 0;
            digits_checked = 0;
            numbers_noted  = 0;
        endfunction

        // split into decimal digits, keep the low MAX_DIGITS, drop leading zeros
        function void note_number(logic [NUM_W-1:0] number);
            longint unsigned rest;
            longint unsigned modulus;
            logic [3:0]      dec[MAX_DIGITS];
            int              used;
            logic [7:0]      sel;
            t_digit_word     w;
            modulus = 1;
            for (int i = 0; i < MAX_DIGITS; i++)
                modulus *= 10;
            rest = number;
            rest = rest % modulus;
            used = 1;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                dec[i] = 4'(rest % 10);
                rest   = rest / 10;
                if (dec[i] != 0)
                    used = i + 1;
            end
            sel = 8'hfe;
            for (int k = 0; k < used; k++) begin
                w.value = dec[used - 1 - k];
                w.segs  = glyph[w.value];
                w.sel   = sel;
                w.last  = (k == used - 1);
                pending_digits.push_back(w);
                sel = {sel[6:0], sel[7]};
            end
            numbers_noted++;
        endfunction

        function void field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_digit(logic [23:0] data, logic tlast);
            t_digit_word w;
            digits_checked++;
            if (pending_digits.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digit word, expected none, got %0h last %0b",
                         $time, data, tlast);
                return;
            end
            w = pending_digits.pop_front();
            field_check("segments", w.segs, data[7:0]);
            field_check("digit_select", w.sel, data[15:8]);
            field_check("digit_value", {4'd0, w.value}, {4'd0, data[19:16]});
            field_check("last_digit", {7'd0, w.last}, {7'd0, tlast});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    int unsigned    gap_pct     = 0;
    int unsigned    stall_pct   = 0;
    int unsigned    cycle_count = 0;
    int unsigned    directed_count;
    t_digit_tracker tracker;

    multiplexed_seven_segment_number_scan_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_digit(m_axis_tdata, m_axis_tlast);
    end

    // leaves tvalid high after acceptance so back-to-back words need no drop
    task automatic send_number(input logic [NUM_W-1:0] n);
        int unsigned gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 45) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(32 - NUM_W){1'b0}}, n};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_number(n);
    endtask

    task automatic drain_digits();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending_digits.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned directed[] = '{
            0, 1, 6, 9, 10, 101, 12345678, 87654321, 90000000, 66666666,
            10000000, 99999999, 100000000, 100000005, 120000000,
            134217727, 67108864, 4444, 5050505
        };
        int unsigned      len;
        int unsigned      lo;
        logic [NUM_W-1:0] n;

        tracker = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i])
            send_number(directed[i][NUM_W-1:0]);
        directed_count = directed.size();
        drain_digits();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 52; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 20) begin
                    n = NUM_W'($urandom);
                end else begin
                    len = $urandom_range(1, MAX_DIGITS);
                    lo  = 1;
                    repeat (len - 1) lo *= 10;
                    n = NUM_W'($urandom_range(lo * 10 - 1, (len == 1) ? 0 : lo));
                end
                send_number(n);
            end
            drain_digits();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d numbers (%0d directed) over four idle/stall mixes,",
                 tracker.numbers_noted, directed_count);
        $display("checked %0d digit words, %0d mismatches.",
                 tracker.digits_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_digits.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/mssn_pkg.sv
sv/mssn_seq.sv
sv/mssn_datapath.sv
sv/multiplexed_seven_segment_number_scan_core.sv
tb/multiplexed_seven_segment_number_scan_core_tb.sv
